// ===== rtl/dlr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the datagram link responder: link modes, event and packet codes,
// register indexes and timing constants. No dependencies.
package dlr_pkg;

	// Link modes (state of the responder).
	localparam logic [1:0] MODE_DISC    = 2'd0;
	localparam logic [1:0] MODE_START   = 2'd1;
	localparam logic [1:0] MODE_WAITACK = 2'd2;
	localparam logic [1:0] MODE_CONN    = 2'd3;

	// Event codes.
	localparam logic [2:0] ACT_OPEN  = 3'd0;
	localparam logic [2:0] ACT_CLOSE = 3'd1;
	localparam logic [2:0] ACT_PKT   = 3'd2;
	localparam logic [2:0] ACT_TICK  = 3'd3;
	localparam logic [2:0] ACT_SEND  = 3'd4;

	// Received packet kinds.
	localparam logic [2:0] PKT_SYNREQ = 3'd0;
	localparam logic [2:0] PKT_SYN    = 3'd1;
	localparam logic [2:0] PKT_ACK    = 3'd2;
	localparam logic [2:0] PKT_KEEP   = 3'd3;
	localparam logic [2:0] PKT_DATA   = 3'd4;

	// Transmitted packet kinds.
	localparam logic [2:0] TX_NONE = 3'd0;
	localparam logic [2:0] TX_SYN  = 3'd1;
	localparam logic [2:0] TX_ACK  = 3'd2;
	localparam logic [2:0] TX_KEEP = 3'd3;
	localparam logic [2:0] TX_DATA = 3'd4;

	// Notices.
	localparam logic [1:0] NOTE_NONE = 2'd0;
	localparam logic [1:0] NOTE_CONN = 2'd1;
	localparam logic [1:0] NOTE_DROP = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_ACK_LIMIT  = 2'd0;
	localparam logic [1:0] REG_KEEP_LIMIT = 2'd1;
	localparam logic [1:0] REG_KEEP_MS    = 2'd2;
	localparam logic [1:0] REG_INIT_SEQ   = 2'd3;

	// Timing constants in milliseconds.
	localparam logic [11:0] ACK_STEP_MS = 12'd3000;
	localparam logic [15:0] SYN_WAIT_MS = 16'd1000;

	// Register reset values.
	localparam logic [3:0]  ACK_LIMIT_RST = 4'd8;
	localparam logic [7:0]  KEEP_LIMIT_RST = 8'd3;
	localparam logic [15:0] KEEP_MS_RST    = 16'd5000;
	localparam logic [15:0] INIT_SEQ_RST   = 16'd0;

	// One result item.
	typedef struct packed {
		logic [2:0]  tx_kind;
		logic [15:0] tx_seq;
		logic        deliver;
		logic [1:0]  notice;
		logic [15:0] timer_delay_ms;
		logic        released;
		logic        bad_packet;
		logic [1:0]  link_state;
	} result_t;

endpackage

// ===== rtl/datagram_link_responder_fsm_unit.sv =====
`timescale 1ns / 1ps
// Datagram link responder: handshake, ack-wait retry and keepalive state machine.
// Depends on dlr_pkg for codes, constants and the result type.
//
// Pipeline: an accepted event passes through the input register, then the result
// register that also updates the link state, before its result reaches the master side.
// Throughput: one event per cycle unless m_tready stalls the result register; the
// state update for an event is done as it moves from the input to the result register.
// Reset: arst_n clears the link state, counters, flags and both stage valids at
// once and restores every configuration register to its default.
module datagram_link_responder_fsm_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Event input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pkt_seq[15:0], pkt_short[16], payload_empty[17], zero pad
	input  logic [5:0]  s_tuser,   // action[2:0], pkt_kind[5:3]
	// Result output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // tx_seq[15:0], deliver[16], notice[18:17],
	                               // timer_delay_ms[34:19], released[35],
	                               // bad_packet[36], link_state[38:37], zero pad
	output logic [2:0]  m_tuser,   // tx_kind[2:0]
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers.
	logic [3:0]  ack_limit_q;
	logic [7:0]  keep_limit_q;
	logic [15:0] keep_ms_q;
	logic [15:0] init_seq_q;

	// Link state.
	logic [1:0]  mode_q;
	logic [15:0] local_seq_q;
	logic [15:0] peer_seq_q;
	logic [7:0]  tick_q;
	logic        sent_q;
	logic        heard_q;

	// Input stage.
	logic        valid_s1;
	logic [2:0]  action_s1;
	logic [2:0]  kind_s1;
	logic [15:0] seq_s1;
	logic        short_s1;
	logic        empty_s1;

	// Result stage.
	logic                 valid_s2;
	dlr_pkg::result_t     res_s2;

	// Next-state and result logic.
	logic [1:0]  mode_d;
	logic [15:0] local_seq_d;
	logic [15:0] peer_seq_d;
	logic [7:0]  tick_d;
	logic        sent_d;
	logic        heard_d;
	dlr_pkg::result_t res_d;
	logic [8:0]  tick_next;
	logic [20:0] ack_delay;
	logic        advance;

	// The input stage moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign tick_next = {1'b0, tick_q} + 9'd1;
	assign ack_delay = tick_next * dlr_pkg::ACK_STEP_MS;

	// Event processing for the item held in the input stage.
	always_comb begin
		mode_d      = mode_q;
		local_seq_d = local_seq_q;
		peer_seq_d  = peer_seq_q;
		tick_d      = tick_q;
		sent_d      = sent_q;
		heard_d     = heard_q;
		res_d       = '0;

		unique case (action_s1)
			dlr_pkg::ACT_OPEN: begin
				mode_d = dlr_pkg::MODE_START;
			end
			dlr_pkg::ACT_CLOSE: begin
				mode_d       = dlr_pkg::MODE_DISC;
				res_d.released = 1'b1;
			end
			dlr_pkg::ACT_PKT: begin
				if (mode_q != dlr_pkg::MODE_DISC) begin
					if (short_s1) begin
						res_d.bad_packet = 1'b1;
					end else begin
						case (kind_s1)
							dlr_pkg::PKT_SYNREQ: begin
								res_d.tx_kind = dlr_pkg::TX_SYN;
								res_d.tx_seq  = local_seq_q;
							end
							dlr_pkg::PKT_SYN: begin
								res_d.tx_kind = dlr_pkg::TX_ACK;
								res_d.tx_seq  = local_seq_q;
								if (mode_q == dlr_pkg::MODE_START) begin
									tick_d               = '0;
									mode_d               = dlr_pkg::MODE_WAITACK;
									res_d.timer_delay_ms = dlr_pkg::SYN_WAIT_MS;
								end
							end
							dlr_pkg::PKT_ACK, dlr_pkg::PKT_KEEP, dlr_pkg::PKT_DATA: begin
								if (kind_s1 != dlr_pkg::PKT_ACK) begin
									heard_d = 1'b1;
								end
								// An ack, keepalive or data packet completes the handshake.
								if (mode_q == dlr_pkg::MODE_WAITACK) begin
									peer_seq_d           = seq_s1;
									mode_d               = dlr_pkg::MODE_CONN;
									tick_d               = '0;
									res_d.timer_delay_ms = keep_ms_q;
									res_d.notice         = dlr_pkg::NOTE_CONN;
								end
								if (kind_s1 == dlr_pkg::PKT_DATA &&
								    mode_d == dlr_pkg::MODE_CONN) begin
									if (empty_s1) begin
										res_d.bad_packet = 1'b1;
									end else begin
										res_d.deliver = 1'b1;
									end
								end
							end
							default: begin
								res_d.bad_packet = 1'b1;
							end
						endcase
					end
				end
			end
			dlr_pkg::ACT_TICK: begin
				if (mode_q == dlr_pkg::MODE_WAITACK) begin
					if (tick_next > {5'd0, ack_limit_q}) begin
						mode_d         = dlr_pkg::MODE_DISC;
						res_d.released = 1'b1;
					end else begin
						// Retry with a delay that grows by one step per tick.
						tick_d        = tick_next[7:0];
						res_d.tx_kind = dlr_pkg::TX_ACK;
						res_d.tx_seq  = local_seq_q;
						res_d.timer_delay_ms = (ack_delay > 21'h00FFFF) ? 16'hFFFF
						                       : ack_delay[15:0];
					end
				end else if (mode_q == dlr_pkg::MODE_CONN) begin
					if (!sent_q) begin
						res_d.tx_kind = dlr_pkg::TX_KEEP;
						res_d.tx_seq  = local_seq_q;
					end else begin
						sent_d = 1'b0;
					end
					if (tick_next > {1'b0, keep_limit_q}) begin
						if (!heard_q) begin
							mode_d         = dlr_pkg::MODE_DISC;
							res_d.released = 1'b1;
							res_d.notice   = dlr_pkg::NOTE_DROP;
						end else begin
							heard_d = 1'b0;
							tick_d  = '0;
						end
					end else begin
						tick_d = tick_next[7:0];
					end
				end
			end
			dlr_pkg::ACT_SEND: begin
				if (mode_q != dlr_pkg::MODE_DISC) begin
					sent_d        = 1'b1;
					local_seq_d   = local_seq_q + 16'd1;
					res_d.tx_kind = dlr_pkg::TX_DATA;
					res_d.tx_seq  = local_seq_q + 16'd1;
				end
			end
			default: begin
			end
		endcase

		res_d.link_state = mode_d;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_limit_q  <= dlr_pkg::ACK_LIMIT_RST;
			keep_limit_q <= dlr_pkg::KEEP_LIMIT_RST;
			keep_ms_q    <= dlr_pkg::KEEP_MS_RST;
			init_seq_q   <= dlr_pkg::INIT_SEQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlr_pkg::REG_ACK_LIMIT:  ack_limit_q  <= cfg_data[3:0];
				dlr_pkg::REG_KEEP_LIMIT: keep_limit_q <= cfg_data[7:0];
				dlr_pkg::REG_KEEP_MS:    keep_ms_q    <= cfg_data;
				dlr_pkg::REG_INIT_SEQ:   init_seq_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Link state registers; writing the initial sequence also reloads local_seq.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= dlr_pkg::MODE_DISC;
			local_seq_q <= dlr_pkg::INIT_SEQ_RST;
			peer_seq_q  <= '0;
			tick_q      <= '0;
			sent_q      <= 1'b0;
			heard_q     <= 1'b0;
		end else begin
			if (advance) begin
				mode_q      <= mode_d;
				peer_seq_q  <= peer_seq_d;
				tick_q      <= tick_d;
				sent_q      <= sent_d;
				heard_q     <= heard_d;
			end
			if (cfg_we && cfg_index == dlr_pkg::REG_INIT_SEQ) begin
				local_seq_q <= cfg_data;
			end else if (advance) begin
				local_seq_q <= local_seq_d;
			end
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser[2:0];
			kind_s1   <= s_tuser[5:3];
			seq_s1    <= s_tdata[15:0];
			short_s1  <= s_tdata[16];
			empty_s1  <= s_tdata[17];
		end
	end

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// Output packing.
	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.tx_kind;
	assign m_tdata  = {1'b0, res_s2.link_state, res_s2.bad_packet, res_s2.released,
	                   res_s2.timer_delay_ms, res_s2.notice, res_s2.deliver,
	                   res_s2.tx_seq};

`ifndef SYNTHESIS
	// A held item in the input stage is never dropped.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage item lost while stalled");

	// A release always leaves the link disconnected.
	a_release_disc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.released |-> res_s2.link_state == dlr_pkg::MODE_DISC)
		else $error("release with link not disconnected");

	// Delivery and a connect notice only happen on a connected link.
	a_deliver_conn: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.deliver || res_s2.notice == dlr_pkg::NOTE_CONN)
		|-> res_s2.link_state == dlr_pkg::MODE_CONN)
		else $error("delivery or connect notice on a link that is not connected");

	// No packet to send means a zero sequence.
	a_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.tx_kind == dlr_pkg::TX_NONE |-> res_s2.tx_seq == 16'd0)
		else $error("sequence set without a packet to send");

	// Only one of deliver and bad_packet is ever raised.
	a_deliver_bad: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.deliver && res_s2.bad_packet))
		else $error("item both delivered and flagged bad");
`endif

endmodule

// ===== tb/sv/tb_datagram_link_responder_fsm_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the datagram link responder state machine.
// Depends on dlr_pkg and datagram_link_responder_fsm_unit; predicts every result item in-line.
module tb_datagram_link_responder_fsm_unit;

	// Codes outside the package: reserved actions and packet kinds.
	localparam logic [2:0] ACT_RSVD     = 3'd5;
	localparam logic [2:0] ACT_RSVD_MAX = 3'd7;
	localparam logic [2:0] PKT_UNKNOWN  = 3'd5;
	localparam logic [2:0] PKT_KIND_MAX = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int FILL_HOLD      = 64;
	localparam int MAX_PRINTS     = 100;

	typedef struct {
		logic [2:0]  action;
		logic [2:0]  kind;
		logic [15:0] seq;
		logic        is_short;
		logic        no_payload;
	} link_event_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // pkt_seq[15:0], pkt_short[16], payload_empty[17], zero pad
	logic [5:0]  s_tuser = '0;   // action[2:0], pkt_kind[5:3]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // tx_seq[15:0], deliver[16], notice[18:17],
	                             // timer_delay_ms[34:19], released[35],
	                             // bad_packet[36], link_state[38:37], zero pad
	logic [2:0]  m_tuser;        // tx_kind[2:0]
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	datagram_link_responder_fsm_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the configuration registers.
	logic [3:0]  cf_ack_limit;
	logic [7:0]  cf_keep_limit;
	logic [15:0] cf_keep_ms;
	logic [15:0] cf_init_seq;

	// Shadow copy of the link state.
	logic [1:0]  lk_mode;
	logic [15:0] lk_local_seq;
	logic [15:0] lk_peer_seq;
	logic [7:0]  lk_ticks;
	logic        lk_sent;
	logic        lk_heard;

	link_event_t          pending_events[$];
	dlr_pkg::result_t     expected_results[$];

	int   queued_items;
	int   mismatch_count = 0;
	int   result_count = 0;
	int   idle_cycles = 0;
	int   src_hold = 0;
	int   sink_hold = 0;
	logic src_gaps_en = 1'b1;
	logic sink_gaps_en = 1'b1;
	logic fill_test = 1'b0;
	logic fill_done = 1'b0;

	link_event_t      drv_item;
	link_event_t      seen_item;
	dlr_pkg::result_t predicted;
	dlr_pkg::result_t got;
	dlr_pkg::result_t want;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Gap length for either side: mostly short, a few long.
	function automatic int gap_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// A peer packet that acknowledges the handshake moves ack wait to connected.
	task automatic accept_peer_ack(input logic [15:0] seq, inout dlr_pkg::result_t r);
		if (lk_mode == dlr_pkg::MODE_WAITACK) begin
			lk_peer_seq      = seq;
			lk_mode          = dlr_pkg::MODE_CONN;
			lk_ticks         = '0;
			r.timer_delay_ms = cf_keep_ms;
			r.notice         = dlr_pkg::NOTE_CONN;
		end
	endtask

	// Advances the shadow link state by one event and returns the result it gives.
	task automatic advance_link(input link_event_t ev, output dlr_pkg::result_t r);
		logic [8:0]  nxt;
		logic [31:0] wait_ms;
		r   = '0;
		nxt = {1'b0, lk_ticks} + 9'd1;
		case (ev.action)
			dlr_pkg::ACT_OPEN: lk_mode = dlr_pkg::MODE_START;
			dlr_pkg::ACT_CLOSE: begin
				lk_mode    = dlr_pkg::MODE_DISC;
				r.released = 1'b1;
			end
			dlr_pkg::ACT_PKT: begin
				if (lk_mode != dlr_pkg::MODE_DISC) begin
					if (ev.is_short) begin
						r.bad_packet = 1'b1;
					end else begin
						case (ev.kind)
							dlr_pkg::PKT_SYNREQ: begin
								r.tx_kind = dlr_pkg::TX_SYN;
								r.tx_seq  = lk_local_seq;
							end
							dlr_pkg::PKT_SYN: begin
								r.tx_kind = dlr_pkg::TX_ACK;
								r.tx_seq  = lk_local_seq;
								if (lk_mode == dlr_pkg::MODE_START) begin
									lk_ticks         = '0;
									lk_mode          = dlr_pkg::MODE_WAITACK;
									r.timer_delay_ms = dlr_pkg::SYN_WAIT_MS;
								end
							end
							dlr_pkg::PKT_ACK: accept_peer_ack(ev.seq, r);
							dlr_pkg::PKT_KEEP: begin
								lk_heard = 1'b1;
								accept_peer_ack(ev.seq, r);
							end
							dlr_pkg::PKT_DATA: begin
								lk_heard = 1'b1;
								accept_peer_ack(ev.seq, r);
								// Data counts only once the link is connected.
								if (lk_mode == dlr_pkg::MODE_CONN) begin
									if (ev.no_payload)
										r.bad_packet = 1'b1;
									else
										r.deliver = 1'b1;
								end
							end
							default: r.bad_packet = 1'b1;
						endcase
					end
				end
			end
			dlr_pkg::ACT_TICK: begin
				if (lk_mode == dlr_pkg::MODE_WAITACK) begin
					// Retry with a growing delay, or give up past the limit.
					if (nxt > {5'b0, cf_ack_limit}) begin
						lk_mode    = dlr_pkg::MODE_DISC;
						r.released = 1'b1;
					end else begin
						wait_ms          = nxt * dlr_pkg::ACK_STEP_MS;
						lk_ticks         = nxt[7:0];
						r.tx_kind        = dlr_pkg::TX_ACK;
						r.tx_seq         = lk_local_seq;
						r.timer_delay_ms = (wait_ms > 32'hFFFF) ? 16'hFFFF : wait_ms[15:0];
					end
				end else if (lk_mode == dlr_pkg::MODE_CONN) begin
					// A keepalive goes out unless data was sent since the last tick.
					if (!lk_sent) begin
						r.tx_kind = dlr_pkg::TX_KEEP;
						r.tx_seq  = lk_local_seq;
					end else begin
						lk_sent = 1'b0;
					end
					if (nxt > {1'b0, cf_keep_limit}) begin
						if (!lk_heard) begin
							lk_mode    = dlr_pkg::MODE_DISC;
							r.released = 1'b1;
							r.notice   = dlr_pkg::NOTE_DROP;
						end else begin
							lk_heard = 1'b0;
							lk_ticks = '0;
						end
					end else begin
						lk_ticks = nxt[7:0];
					end
				end
			end
			dlr_pkg::ACT_SEND: begin
				if (lk_mode != dlr_pkg::MODE_DISC) begin
					lk_sent      = 1'b1;
					lk_local_seq = lk_local_seq + 16'd1;
					r.tx_kind    = dlr_pkg::TX_DATA;
					r.tx_seq     = lk_local_seq;
				end
			end
			default: ;
		endcase
		r.link_state = lk_mode;
	endtask

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what, input logic [15:0] seen,
		input logic [15:0] wanted);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t result %0d: %s got %0h expected %0h", $realtime, result_count,
				what, seen, wanted);
	endtask

	// Queues one item for the driver.
	task automatic add_item(input logic [2:0] action, input logic [2:0] kind,
		input logic [15:0] seq, input logic is_short, input logic no_payload);
		link_event_t ev;
		ev.action     = action;
		ev.kind       = kind;
		ev.seq        = seq;
		ev.is_short   = is_short;
		ev.no_payload = no_payload;
		pending_events.push_back(ev);
		queued_items++;
	endtask

	// Any field combination at all.
	task automatic add_noise();
		add_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 16'($urandom()),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// One link lifetime: open, handshake, traffic, then sometimes a close or a timeout.
	task automatic add_session();
		int n;
		int r;
		add_item(dlr_pkg::ACT_OPEN, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
		if ($urandom_range(0, 3) == 0)
			add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_SYN, 16'($urandom()),
			$urandom_range(0, 9) == 0, 1'b0);
		// Retries in ack wait, sometimes long enough to time out.
		n = $urandom_range(0, 3);
		if ($urandom_range(0, 7) == 0)
			n = 16;
		repeat (n)
			add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, 3'($urandom_range(dlr_pkg::PKT_ACK, dlr_pkg::PKT_DATA)),
			16'($urandom()), $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
		n = $urandom_range(8, 30);
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				add_item(dlr_pkg::ACT_SEND, 3'($urandom_range(0, 7)), 16'($urandom()),
					1'b0, 1'b0);
			else if (r < 50)
				add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_DATA, 16'($urandom()),
					$urandom_range(0, 19) == 0, $urandom_range(0, 6) == 0);
			else if (r < 60)
				add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_KEEP, 16'($urandom()), 1'b0, 1'b0);
			else if (r < 85)
				add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
			else if (r < 97)
				add_noise();
			else
				add_item(dlr_pkg::ACT_CLOSE, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
		end
		// Either let the keepalive run out, close, or leave the link as it is.
		if ($urandom_range(0, 2) == 0) begin
			repeat (20)
				add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
		end else if ($urandom_range(0, 1) == 0) begin
			add_item(dlr_pkg::ACT_CLOSE, dlr_pkg::PKT_SYNREQ, 16'($urandom()), 1'b0, 1'b0);
		end
	endtask

	task automatic add_random_items(input int count);
		queued_items = 0;
		while (queued_items < count) begin
			if ($urandom_range(0, 9) == 0)
				add_noise();
			else
				add_session();
		end
	endtask

	// Writes one register; the block is idle whenever this is called.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dlr_pkg::REG_ACK_LIMIT:  cf_ack_limit = value[3:0];
			dlr_pkg::REG_KEEP_LIMIT: cf_keep_limit = value[7:0];
			dlr_pkg::REG_KEEP_MS:    cf_keep_ms = value;
			dlr_pkg::REG_INIT_SEQ: begin
				cf_init_seq  = value;
				lk_local_seq = value;
			end
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [3:0] ack_limit, input logic [7:0] keep_limit,
		input logic [15:0] keep_ms, input logic [15:0] init_seq);
		write_reg(dlr_pkg::REG_ACK_LIMIT, {12'd0, ack_limit});
		write_reg(dlr_pkg::REG_KEEP_LIMIT, {8'd0, keep_limit});
		write_reg(dlr_pkg::REG_KEEP_MS, keep_ms);
		write_reg(dlr_pkg::REG_INIT_SEQ, init_seq);
	endtask

	// Waits until every queued item went in and every result came out.
	task automatic wait_drain();
		while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Driver: presents the next queued item once the bus is free, with random gaps.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (src_hold != 0) begin
				src_hold <= src_hold - 1;
				s_tvalid <= 1'b0;
			end else if (pending_events.size() != 0) begin
				drv_item = pending_events.pop_front();
				s_tdata  <= {6'd0, drv_item.no_payload, drv_item.is_short, drv_item.seq};
				s_tuser  <= {drv_item.kind, drv_item.action};
				s_tvalid <= 1'b1;
				if (src_gaps_en && $urandom_range(0, 99) < 25)
					src_hold <= gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that fills the block.
	always @(posedge clk) begin
		if (arst_n) begin
			if (fill_test && !fill_done) begin
				fill_done <= 1'b1;
				sink_hold <= FILL_HOLD;
				m_tready  <= 1'b0;
			end else if (sink_hold != 0) begin
				sink_hold <= sink_hold - 1;
				m_tready  <= 1'b0;
			end else if (sink_gaps_en && $urandom_range(0, 99) < 25) begin
				sink_hold <= gap_len() - 1;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Each accepted item is run through the shadow state to get its result.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			seen_item.seq        = s_tdata[15:0];
			seen_item.is_short   = s_tdata[16];
			seen_item.no_payload = s_tdata[17];
			seen_item.action     = s_tuser[2:0];
			seen_item.kind       = s_tuser[5:3];
			advance_link(seen_item, predicted);
			expected_results.push_back(predicted);
		end
	end

	// Each accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.tx_kind        = m_tuser;
			got.tx_seq         = m_tdata[15:0];
			got.deliver        = m_tdata[16];
			got.notice         = m_tdata[18:17];
			got.timer_delay_ms = m_tdata[34:19];
			got.released       = m_tdata[35];
			got.bad_packet     = m_tdata[36];
			got.link_state     = m_tdata[38:37];
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, tx_seq", got.tx_seq, 16'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.tx_kind !== want.tx_kind)
					report_mismatch("tx_kind", 16'(got.tx_kind), 16'(want.tx_kind));
				if (got.tx_seq !== want.tx_seq)
					report_mismatch("tx_seq", got.tx_seq, want.tx_seq);
				if (got.deliver !== want.deliver)
					report_mismatch("deliver", 16'(got.deliver), 16'(want.deliver));
				if (got.notice !== want.notice)
					report_mismatch("notice", 16'(got.notice), 16'(want.notice));
				if (got.timer_delay_ms !== want.timer_delay_ms)
					report_mismatch("timer_delay_ms", got.timer_delay_ms, want.timer_delay_ms);
				if (got.released !== want.released)
					report_mismatch("released", 16'(got.released), 16'(want.released));
				if (got.bad_packet !== want.bad_packet)
					report_mismatch("bad_packet", 16'(got.bad_packet), 16'(want.bad_packet));
				if (got.link_state !== want.link_state)
					report_mismatch("link_state", 16'(got.link_state), 16'(want.link_state));
			end
			result_count++;
		end
	end

	// Watchdog: ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Sequencer: reset, directed items, then random phases under several settings.
	initial begin
		cf_ack_limit  = dlr_pkg::ACK_LIMIT_RST;
		cf_keep_limit = dlr_pkg::KEEP_LIMIT_RST;
		cf_keep_ms    = dlr_pkg::KEEP_MS_RST;
		cf_init_seq   = dlr_pkg::INIT_SEQ_RST;
		lk_mode       = dlr_pkg::MODE_DISC;
		lk_local_seq  = dlr_pkg::INIT_SEQ_RST;
		lk_peer_seq   = '0;
		lk_ticks      = '0;
		lk_sent       = 1'b0;
		lk_heard      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: everything ignored while disconnected.
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_SYN, 16'h1234, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_SEND, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(ACT_RSVD, PKT_KIND_MAX, 16'hFFFF, 1'b1, 1'b1);
		add_item(ACT_RSVD_MAX, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		// Start state: ticks do nothing, bad packets are flagged, data is dropped.
		add_item(dlr_pkg::ACT_OPEN, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_SYNREQ, 16'h0001, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_DATA, 16'h0002, 1'b1, 1'b0);
		add_item(dlr_pkg::ACT_PKT, PKT_KIND_MAX, 16'h0003, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, PKT_UNKNOWN, 16'h0004, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_DATA, 16'h0005, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_ACK, 16'h0006, 1'b0, 1'b0);
		// Handshake, two retries, then a data packet connects and is delivered.
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_SYN, 16'h0007, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_DATA, 16'hFFFF, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_PKT, dlr_pkg::PKT_DATA, 16'h8000, 1'b0, 1'b1);
		add_item(dlr_pkg::ACT_SEND, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		// Keepalive ticks until the link is dropped for silence.
		repeat (8)
			add_item(dlr_pkg::ACT_TICK, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		add_item(dlr_pkg::ACT_CLOSE, dlr_pkg::PKT_SYNREQ, 16'h0000, 1'b0, 1'b0);
		wait_drain();

		// Lowest limits, widest delay and a sequence that wraps on the first send.
		write_all(4'd1, 8'd1, 16'hFFFF, 16'hFFFF);
		add_random_items(150);
		wait_drain();

		// Highest limits, shortest delay; no idling, and one long receiver hold-off.
		src_gaps_en  <= 1'b0;
		sink_gaps_en <= 1'b0;
		write_all(4'd15, 8'd255, 16'd1, 16'd0);
		add_random_items(150);
		fill_test <= 1'b1;
		wait_drain();

		// Mid-range settings with idling on both sides.
		src_gaps_en  <= 1'b1;
		sink_gaps_en <= 1'b1;
		write_all(4'($urandom_range(1, 15)), 8'($urandom_range(1, 8)),
			16'($urandom_range(1, 65535)), 16'($urandom()));
		add_random_items(300);
		wait_drain();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
